### src/mrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the 64-bit Miller-Rabin tester
// Word type, witness base table, and the status struct of the mulmod unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int Width     = 64;
  localparam int ShiftW    = $clog2(Width);        // holds s, r and bit counts
  localparam int BaseCount = 9;
  localparam int BaseIdxW  = $clog2(BaseCount + 1);
  localparam int BaseW     = 5;                    // widest base is 23

  typedef logic [Width-1:0] word_t;

  // Status of the modular multiplier as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, product valid
  } mm_stat_t;

  // Fixed witness bases 2, 3, 5, 7, 11, 13, 17, 19, 23.
  function automatic logic [BaseW-1:0] base_of(input logic [BaseIdxW-1:0] idx);
    logic [BaseW-1:0] b;
    case (idx)
      4'd0:    b = 5'd2;
      4'd1:    b = 5'd3;
      4'd2:    b = 5'd5;
      4'd3:    b = 5'd7;
      4'd4:    b = 5'd11;
      4'd5:    b = 5'd13;
      4'd6:    b = 5'd17;
      4'd7:    b = 5'd19;
      4'd8:    b = 5'd23;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

endpackage

### src/mrpt_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_mulmod: bit-serial modular multiplier
// Computes (x * y) mod m by shift-add, MSB of y first, with one modular add
// per cycle: a doubling step and a conditional add step per bit of y.
// Operands must already be below m.
// ----------------------------------------------------------------------------
module mrpt_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mrpt_pkg::word_t   x_i,
  input  mrpt_pkg::word_t   y_i,
  input  mrpt_pkg::word_t   m_i,
  output mrpt_pkg::mm_stat_t stat_o,
  output mrpt_pkg::word_t   prod_o
);
  import mrpt_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              phase_q, phase_d;   // 0: double, 1: add x
  logic [ShiftW-1:0] cnt_q, cnt_d;
  word_t             acc_q, acc_d;
  word_t             x_q, x_d;
  word_t             y_q, y_d;
  word_t             m_q, m_d;

  // shared modular adder: acc + opb mod m, both below m
  word_t           opb;
  logic [Width:0]  sum;
  logic [Width+1:0] diff;
  word_t           addmod;

  assign opb    = phase_q ? x_q : acc_q;
  assign sum    = {1'b0, acc_q} + {1'b0, opb};
  assign diff   = {1'b0, sum} - {2'b00, m_q};
  assign addmod = diff[Width+1] ? sum[Width-1:0] : diff[Width-1:0];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    m_d     = m_q;
    if (busy_q) begin
      if (!phase_q) begin
        acc_d   = addmod;
        phase_d = 1'b1;
      end else begin
        if (y_q[Width-1]) begin
          acc_d = addmod;
        end
        y_d     = {y_q[Width-2:0], 1'b0};
        phase_d = 1'b0;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - ShiftW'(1);
        end
      end
    end else if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = ShiftW'(Width - 1);
      acc_d   = '0;
      x_d     = x_i;
      y_d     = y_i;
      m_d     = m_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

  // accumulator stays reduced for the whole run
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$rose(busy_q) |-> acc_q < m_q)
    else $error("mulmod accumulator not reduced");

  // done only at the end of a run
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $fell(busy_q))
    else $error("mulmod done without a finished run");

  // a start while idle always launches a run
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_q |=> busy_q)
    else $error("mulmod start ignored");

endmodule

### src/miller_rabin_prime_test_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64: deterministic Miller-Rabin test of a 64-bit word
// Sequencer around one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Takes one unsigned 64-bit candidate per input word and returns one is_prime
// word. 0, 1 and even numbers other than 2 are decided without any modular
// product. An odd n is split as n-1 = d*2^s (one bit per cycle), then tested
// with bases 2..23, skipping any base >= n. Every modular product runs
// through a single shift-add multiplier, so the run time is set by that unit:
// per base roughly (bits(d) + popcount(d) + s) products, at most about 128;
// a composite usually exits after the first base. The block accepts no new
// word while a test runs; a finished result sits in an output register, so
// the next candidate can be taken while that result waits.
// Answers are exact for n < 3825123056546413051; above that a strong
// pseudoprime to all nine bases reports 1.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mrpt_pkg::word_t candidate_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            is_prime_o
);
  import mrpt_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECOMP  = 4'd1;  // strip factors of two from n-1
  localparam logic [3:0] S_BASE    = 4'd2;  // pick next base or finish
  localparam logic [3:0] S_POW_CHK = 4'd3;  // next exponent bit
  localparam logic [3:0] S_POW_RES = 4'd4;  // res = res*b
  localparam logic [3:0] S_POW_SQ  = 4'd5;  // b = b*b
  localparam logic [3:0] S_TEST    = 4'd6;  // a^d == 1 ?
  localparam logic [3:0] S_SQ_CHK  = 4'd7;  // x == n-1 ?
  localparam logic [3:0] S_SQ_WAIT = 4'd8;  // x = x*x
  localparam logic [3:0] S_FINISH  = 4'd9;  // hand verdict to output reg

  logic [3:0]          state_q, state_d;
  word_t               n_q, n_d;
  word_t               nm1_q, nm1_d;      // n-1
  word_t               d_q, d_d;          // odd part of n-1
  word_t               e_q, e_d;          // running exponent
  word_t               res_q, res_d;      // running power / x
  word_t               b_q, b_d;          // running base square
  logic [ShiftW-1:0]   s_q, s_d;
  logic [ShiftW-1:0]   r_q, r_d;
  logic [BaseIdxW-1:0] k_q, k_d;
  logic                verdict_q, verdict_d;
  logic                out_valid_q, out_valid_d;
  logic                is_prime_q, is_prime_d;

  // multiplier hookup
  logic     mm_start;
  word_t    mm_x, mm_y;
  word_t    mm_prod;
  mm_stat_t mm_stat;

  logic [BaseW-1:0] base_a;
  logic             base_skip;
  logic             out_free;

  assign base_a    = base_of(k_q);
  assign base_skip = {{(Width-BaseW){1'b0}}, base_a} >= n_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    nm1_d       = nm1_q;
    d_d         = d_q;
    e_d         = e_q;
    res_d       = res_q;
    b_d         = b_q;
    s_d         = s_q;
    r_d         = r_q;
    k_d         = k_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    mm_start    = 1'b0;
    mm_x        = b_q;
    mm_y        = b_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d   = candidate_i;
          nm1_d = candidate_i - word_t'(1);
          d_d   = candidate_i - word_t'(1);
          s_d   = '0;
          if (candidate_i[Width-1:1] == '0) begin
            verdict_d = 1'b0;                 // 0 and 1
            state_d   = S_FINISH;
          end else if (candidate_i == word_t'(2)) begin
            verdict_d = 1'b1;
            state_d   = S_FINISH;
          end else if (!candidate_i[0]) begin
            verdict_d = 1'b0;                 // other even numbers
            state_d   = S_FINISH;
          end else begin
            state_d = S_DECOMP;
          end
        end
      end
      S_DECOMP: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[Width-1:1]};
          s_d = s_q + ShiftW'(1);
        end else begin
          k_d     = '0;
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        if (k_q == BaseIdxW'(BaseCount)) begin
          verdict_d = 1'b1;
          state_d   = S_FINISH;
        end else if (base_skip) begin
          k_d = k_q + BaseIdxW'(1);
        end else begin
          res_d   = word_t'(1);
          b_d     = {{(Width-BaseW){1'b0}}, base_a};
          e_d     = d_q;
          state_d = S_POW_CHK;
        end
      end
      S_POW_CHK: begin
        if (e_q == '0) begin
          state_d = S_TEST;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_x     = res_q;
          mm_y     = b_q;
          state_d  = S_POW_RES;
        end else begin
          mm_start = 1'b1;
          state_d  = S_POW_SQ;
        end
      end
      S_POW_RES: begin
        if (mm_stat.done) begin
          res_d    = mm_prod;
          mm_start = 1'b1;                    // b*b follows at once
          state_d  = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        if (mm_stat.done) begin
          b_d     = mm_prod;
          e_d     = {1'b0, e_q[Width-1:1]};
          state_d = S_POW_CHK;
        end
      end
      S_TEST: begin
        if (res_q == word_t'(1)) begin
          k_d     = k_q + BaseIdxW'(1);
          state_d = S_BASE;
        end else begin
          r_d     = '0;
          state_d = S_SQ_CHK;
        end
      end
      S_SQ_CHK: begin
        if (r_q == s_q) begin
          verdict_d = 1'b0;                   // witness found: composite
          state_d   = S_FINISH;
        end else if (res_q == nm1_q) begin
          k_d     = k_q + BaseIdxW'(1);
          state_d = S_BASE;
        end else begin
          mm_start = 1'b1;
          mm_x     = res_q;
          mm_y     = res_q;
          state_d  = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (mm_stat.done) begin
          res_d   = mm_prod;
          r_d     = r_q + ShiftW'(1);
          state_d = S_SQ_CHK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_prime_d  = verdict_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (n_q),
    .stat_o  (mm_stat),
    .prod_o  (mm_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      s_q         <= '0;
      r_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      s_q         <= s_d;
      r_q         <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nm1_q      <= nm1_d;
    d_q        <= d_d;
    e_q        <= e_d;
    res_q      <= res_d;
    b_q        <= b_d;
    verdict_q  <= verdict_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  // never hand the multiplier a new job while it runs
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  // idle sequencer means no multiplication in flight
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mm_stat.busy)
    else $error("multiplier busy while sequencer idle");

  // squaring count never passes s, base index never passes the table
  a_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ_CHK |-> r_q <= s_q) and (k_q <= BaseIdxW'(BaseCount)))
    else $error("loop counter out of range");

endmodule
